### hdl/mcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcr_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_CLIP_LOW  = 1'b0;
  localparam logic REG_CLIP_HIGH = 1'b1;

  localparam logic [7:0] CLIP_LOW_RST  = 8'd1;
  localparam logic [7:0] CLIP_HIGH_RST = 8'd255;

  localparam int GRID_SIZE_DEF = 256;

  // Depth of the job queue between front and back.
  localparam int JOB_DEPTH = 2;

  // Kind of job handed from front to back.
  localparam logic [1:0] KIND_IDLE    = 2'd0;
  localparam logic [1:0] KIND_OUTLINE = 2'd1;
  localparam logic [1:0] KIND_SOLID   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [23:0] color;
    logic        fin;
  } job_t;

endpackage
`default_nettype wire

### hdl/mcr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mcr_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 accept_i,
  input  wire                 operation_i,
  input  wire  [7:0]          center_x_i,
  input  wire  [7:0]          center_y_i,
  input  wire  [7:0]          radius_i,
  input  wire                 solid_i,
  input  wire  [23:0]         color_i,
  output logic                job_push_o,
  output mcr_pkg::job_t       job_o
);

  logic               busy_q, busy_d;
  logic signed [9:0]  x_q, x_d;
  logic signed [9:0]  y_q, y_d;
  logic signed [10:0] err_q, err_d;
  logic [7:0]         cx_q, cx_d;
  logic [7:0]         cy_q, cy_d;
  logic               solid_q, solid_d;
  logic [23:0]        color_q, color_d;

  logic signed [9:0]  y_next;
  logic signed [9:0]  x_next;
  logic signed [9:0]  diff;
  logic signed [10:0] err_next;
  logic               fin;

  // Midpoint update for the current octant step.
  always_comb begin
    y_next = y_q + 10'sd1;
    diff   = '0;
    if (err_q < 0) begin
      x_next   = x_q;
      err_next = err_q + $signed({y_next, 1'b1});
    end else begin
      x_next   = x_q - 10'sd1;
      diff     = y_next - x_next + 10'sd1;
      err_next = err_q + $signed({diff, 1'b0});
    end
    fin = (x_next < y_next);
  end

  always_comb begin
    busy_d  = busy_q;
    x_d     = x_q;
    y_d     = y_q;
    err_d   = err_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    solid_d = solid_q;
    color_d = color_q;
    job_push_o = 1'b0;
    job_o      = '0;
    if (accept_i) begin
      if (operation_i == mcr_pkg::OP_START) begin
        busy_d  = 1'b1;
        x_d     = {2'b00, radius_i};
        y_d     = '0;
        err_d   = 11'sd1 - $signed({3'b000, radius_i});
        cx_d    = center_x_i;
        cy_d    = center_y_i;
        solid_d = solid_i;
        color_d = color_i;
      end else begin
        job_push_o = 1'b1;
        if (!busy_q) begin
          job_o.kind = mcr_pkg::KIND_IDLE;
          job_o.fin  = 1'b1;
        end else begin
          job_o.kind  = solid_q ? mcr_pkg::KIND_SOLID : mcr_pkg::KIND_OUTLINE;
          job_o.x     = x_q[8:0];
          job_o.y     = y_q[8:0];
          job_o.cx    = cx_q;
          job_o.cy    = cy_q;
          job_o.color = color_q;
          job_o.fin   = fin;
          x_d   = x_next;
          y_d   = y_next;
          err_d = err_next;
          if (fin) begin
            busy_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      err_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      solid_q <= 1'b0;
      color_q <= '0;
    end else begin
      busy_q  <= busy_d;
      x_q     <= x_d;
      y_q     <= y_d;
      err_q   <= err_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      solid_q <= solid_d;
      color_q <= color_d;
    end
  end

endmodule
`default_nettype wire

### hdl/mcr_job_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mcr_job_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  mcr_pkg::job_t       job_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                valid_o,
  output mcr_pkg::job_t       job_o
);

  localparam int PtrW = (mcr_pkg::JOB_DEPTH > 1) ? $clog2(mcr_pkg::JOB_DEPTH) : 1;
  localparam int CntW = $clog2(mcr_pkg::JOB_DEPTH + 1);

  mcr_pkg::job_t     mem_q [mcr_pkg::JOB_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CntW'(mcr_pkg::JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(mcr_pkg::JOB_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(mcr_pkg::JOB_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### hdl/mcr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mcr_back #(
  parameter int GridSize = mcr_pkg::GRID_SIZE_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 job_valid_i,
  input  mcr_pkg::job_t       job_i,
  output logic                job_pop_o,
  input  wire  [7:0]          clip_low_i,
  input  wire  [7:0]          clip_high_i,
  input  wire                 pop_i,
  output logic                empty_o,
  output logic signed [9:0]   pos_x_o,
  output logic signed [9:0]   pos_y_o,
  output logic signed [9:0]   span_end_x_o,
  output logic                is_span_o,
  output logic                visible_o,
  output logic [23:0]         pixel_color_o,
  output logic                last_o,
  output logic                finished_o
);

  localparam int GridMax = (GridSize - 1 > 255) ? 255 : GridSize - 1;
  localparam logic [7:0] GridMaxV = GridMax[7:0];

  logic               busy_q;
  mcr_pkg::job_t      job_q;
  logic [7:0]         pend_q;
  logic               filler_q;
  logic               out_valid_q;

  logic [7:0]         one_hot;
  logic [7:0]         rest;
  logic [2:0]         idx;
  logic               last;
  logic               advance;
  logic               load;
  logic [7:0]         pend_init;
  logic               filler_init;
  logic [3:0]         span_ok;

  logic [7:0]         win_hi;
  logic signed [9:0]  lo_s, hi_s;
  logic signed [9:0]  cx_s, cy_s, x_s, y_s;
  logic signed [9:0]  a, b, h, row_off;
  logic signed [9:0]  px, py, ex, left, right;
  logic               span, vis;

  assign win_hi = (clip_high_i > GridMaxV) ? GridMaxV : clip_high_i;
  assign lo_s   = $signed({2'b00, clip_low_i});
  assign hi_s   = $signed({2'b00, win_hi});

  // Lowest pending result goes out first.
  always_comb begin
    one_hot = pend_q & (~pend_q + 8'd1);
    rest    = pend_q & ~one_hot;
    last    = (rest == '0);
    idx     = '0;
    for (int i = 7; i >= 0; i--) begin
      if (pend_q[i]) begin
        idx = 3'(i);
      end
    end
  end

  assign empty_o   = !out_valid_q;
  assign advance   = busy_q && (!out_valid_q || pop_i);
  assign load      = job_valid_i && (!busy_q || (advance && last));
  assign job_pop_o = load;

  // Spans of zero width are dropped before they are queued for output.
  always_comb begin
    span_ok     = {job_i.y != '0, job_i.x != '0, job_i.x != '0, job_i.y != '0};
    filler_init = 1'b0;
    case (job_i.kind)
      mcr_pkg::KIND_OUTLINE: pend_init = 8'hFF;
      mcr_pkg::KIND_SOLID: begin
        if (span_ok == '0) begin
          pend_init   = 8'h01;
          filler_init = 1'b1;
        end else begin
          pend_init = {4'h0, span_ok};
        end
      end
      default: pend_init = 8'h01;
    endcase
  end

  always_comb begin
    cx_s = $signed({2'b00, job_q.cx});
    cy_s = $signed({2'b00, job_q.cy});
    x_s  = $signed({1'b0, job_q.x});
    y_s  = $signed({1'b0, job_q.y});
    a       = idx[0] ? y_s : x_s;
    b       = idx[0] ? x_s : y_s;
    h       = (idx[0] ^ idx[1]) ? x_s : y_s;
    row_off = (idx[0] ^ idx[1]) ? y_s : x_s;
    left    = cx_s - h;
    right   = cx_s + h - 10'sd1;
    if (left < lo_s) begin
      left = lo_s;
    end
    if (right > hi_s) begin
      right = hi_s;
    end
    px   = '0;
    py   = '0;
    ex   = '0;
    span = 1'b0;
    vis  = 1'b0;
    case (job_q.kind)
      mcr_pkg::KIND_OUTLINE: begin
        px  = (idx[2] ^ idx[1]) ? cx_s - a : cx_s + a;
        py  = idx[2] ? cy_s - b : cy_s + b;
        ex  = px;
        vis = (px >= lo_s) && (px <= hi_s) && (py >= lo_s) && (py <= hi_s);
      end
      mcr_pkg::KIND_SOLID: begin
        span = 1'b1;
        if (filler_q) begin
          px = cx_s;
          py = cy_s;
          ex = cx_s;
        end else begin
          px  = left;
          ex  = right;
          py  = idx[1] ? cy_s + row_off : cy_s - row_off;
          vis = (py >= lo_s) && (py <= hi_s) && (left <= right);
        end
      end
      default: begin
        px = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= '0;
      filler_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q   <= 1'b1;
        pend_q   <= pend_init;
        filler_q <= filler_init;
      end else if (advance) begin
        pend_q <= rest;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (advance) begin
      pos_x_o       <= px;
      pos_y_o       <= py;
      span_end_x_o  <= ex;
      is_span_o     <= span;
      visible_o     <= vis;
      pixel_color_o <= (job_q.kind == mcr_pkg::KIND_IDLE) ? 24'd0 : job_q.color;
      last_o        <= last;
      finished_o    <= job_q.fin;
    end
  end

endmodule
`default_nettype wire

### hdl/midpoint_circle_raster_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Midpoint circle rasterizer. A start transaction (operation 0) loads the
// center, radius, color and fill mode and produces no result. Each step
// transaction (operation 1) produces one batch for the current octant
// position: eight outline points, or up to four horizontal spans in solid
// mode, every one clipped against the window set by the clip_low and
// clip_high registers (a result wholly outside still appears with visible low).
// The last result of a batch has last set, and every result of the step
// that completes the circle has finished set. A step with no circle active
// yields a single result with finished set. The front stage updates the
// circle state once per accepted transaction and hands a job to a
// two-entry queue; the back stage emits one result per cycle, when its
// single output result register is empty or being popped.
// Configuration should only be written while no results are outstanding.
module midpoint_circle_raster_unit #(
  parameter int GridSize = mcr_pkg::GRID_SIZE_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Input queue side.
  input  wire                 push,
  output logic                full,
  input  wire                 operation_i,
  input  wire  [7:0]          center_x_i,
  input  wire  [7:0]          center_y_i,
  input  wire  [7:0]          radius_i,
  input  wire                 solid_i,
  input  wire  [23:0]         color_i,
  // Result queue side.
  output logic                empty,
  input  wire                 pop,
  output logic signed [9:0]   pos_x_o,
  output logic signed [9:0]   pos_y_o,
  output logic signed [9:0]   span_end_x_o,
  output logic                is_span_o,
  output logic                visible_o,
  output logic [23:0]         pixel_color_o,
  output logic                last_o,
  output logic                finished_o,
  // Configuration port.
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0]    clip_low_q, clip_low_d;
  logic [7:0]    clip_high_q, clip_high_d;
  logic          cfg_write;
  logic          reg_sel;

  logic          accept;
  logic          job_push;
  mcr_pkg::job_t job_in;
  logic          job_valid;
  logic          job_pop;
  mcr_pkg::job_t job_out;

  // Registers sit at byte addresses 0 and 4; bit 2 of the address picks one.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    clip_low_d  = clip_low_q;
    clip_high_d = clip_high_q;
    if (cfg_write) begin
      case (reg_sel)
        mcr_pkg::REG_CLIP_LOW:  clip_low_d  = pwdata[7:0];
        mcr_pkg::REG_CLIP_HIGH: clip_high_d = pwdata[7:0];
        default:                clip_low_d  = clip_low_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mcr_pkg::REG_CLIP_LOW:  prdata = {24'd0, clip_low_q};
      mcr_pkg::REG_CLIP_HIGH: prdata = {24'd0, clip_high_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_low_q  <= mcr_pkg::CLIP_LOW_RST;
      clip_high_q <= mcr_pkg::CLIP_HIGH_RST;
    end else begin
      clip_low_q  <= clip_low_d;
      clip_high_q <= clip_high_d;
    end
  end

  // The input side stalls only when the job queue has no room.
  assign accept = push && !full;

  mcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .solid_i     (solid_i),
    .color_i     (color_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  mcr_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  mcr_back #(
    .GridSize (GridSize)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_out),
    .job_pop_o     (job_pop),
    .clip_low_i    (clip_low_q),
    .clip_high_i   (clip_high_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .span_end_x_o  (span_end_x_o),
    .is_span_o     (is_span_o),
    .visible_o     (visible_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o),
    .finished_o    (finished_o)
  );

endmodule
`default_nettype wire
